[rtl/core/flrfm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// flrfm_pkg
// Shared types, register indexes and the CRC-8 step for the framed link
// receiver with fault monitor.
// ----------------------------------------------------------------------------
package flrfm_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 41;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_BYTE = 4'd0,
        REG_MAX_ERRORS = 4'd1,
        REG_HB_TIMEOUT = 4'd2,
        REG_SYNC_GRACE = 4'd3,
        REG_RANGE_0    = 4'd4
    } cfg_reg_t;

    // Deframer position within a five-byte frame
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_VAL_HI = 3'd2,
        PH_VAL_LO = 3'd3,
        PH_CRC    = 3'd4
    } frame_phase_t;

    // Range table entry, laid out as written on the configuration port
    typedef struct packed {
        logic        valid;
        logic [7:0]  ptype;
        logic [15:0] lo_val;
        logic [15:0] hi_val;
    } range_entry_t;

    // One result item
    typedef struct packed {
        logic        packet_valid;
        logic [7:0]  packet_type;
        logic [15:0] packet_value;
        logic [7:0]  error_count;
        logic        comm_fault;
        logic        heartbeat_fault;
        logic        sync_fault;
        logic        latched_fault;
    } result_t;

    // Fold one byte into a CRC-8 (MSB first, no reflection)
    function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/flrfm_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// flrfm_in_if
// Input item channel: a received byte or a millisecond tick.
// ----------------------------------------------------------------------------
interface flrfm_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/flrfm_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// flrfm_out_if
// Result item channel: delivered packet and fault status.
// ----------------------------------------------------------------------------
interface flrfm_out_if;
    logic        valid;
    logic        ready;
    logic        packet_valid;
    logic [7:0]  packet_type;
    logic [15:0] packet_value;
    logic [7:0]  error_count;
    logic        comm_fault;
    logic        heartbeat_fault;
    logic        sync_fault;
    logic        latched_fault;

    modport source (
        output valid, output packet_valid, output packet_type, output packet_value,
        output error_count, output comm_fault, output heartbeat_fault,
        output sync_fault, output latched_fault, input ready
    );
    modport sink (
        input valid, input packet_valid, input packet_type, input packet_value,
        input error_count, input comm_fault, input heartbeat_fault,
        input sync_fault, input latched_fault, output ready
    );
endinterface
`default_nettype wire

[rtl/core/flrfm_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// flrfm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface flrfm_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [40:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/framed_link_receiver_fault_monitor_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// framed_link_receiver_fault_monitor_unit
// Deframes CRC-8 protected five-byte packets, validates them against a range
// table and tracks comm, heartbeat and sync faults on millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   item   - one received byte (kind 0) or one millisecond tick (kind 1).
//   result - exactly one item per input item: the delivered packet, if any,
//            and the current error count and fault flags.
//   cfg    - register writes, always ready; write only while the block is
//            idle. Indexes beyond the register list are ignored.
// Path: an accepted item is held in the input register, then its status is
//   registered in the result register. Throughput: one item per cycle while
//   result is not held; the limit is the single state update per item
//   (deframer, CRC step, range compare, uptime and heartbeat arithmetic)
//   done between the two registers.
// Reset: all configuration registers return to their defaults, the deframer
//   hunts for a start byte, counters and fault flags clear.
// Stall: when result is held, the finished item waits in the result register
//   while the next item still enters the input register; only then does the
//   item channel drop ready.
// ----------------------------------------------------------------------------
module framed_link_receiver_fault_monitor_unit
    import flrfm_pkg::*;
#(
    parameter int RANGE_ENTRIES  = 4,
    parameter int HEARTBEAT_TYPE = 240,
    parameter int BOOT_ID_TYPE   = 241
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    flrfm_in_if.sink         item,
    flrfm_out_if.source      result,
    flrfm_cfg_if.sink        cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]   start_byte_reg;
    logic [7:0]   max_errors_reg;
    logic [15:0]  hb_timeout_reg;
    logic [15:0]  sync_grace_reg;
    range_entry_t range_reg [RANGE_ENTRIES];

    logic cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'hAA;
            max_errors_reg <= 8'd10;
            hb_timeout_reg <= 16'd1000;
            sync_grace_reg <= 16'd3000;
        end
        else if (cfg_we)
        begin
            case (cfg.index)
                REG_START_BYTE: start_byte_reg <= cfg.data[7:0];
                REG_MAX_ERRORS: max_errors_reg <= cfg.data[7:0];
                REG_HB_TIMEOUT: hb_timeout_reg <= cfg.data[15:0];
                REG_SYNC_GRACE: sync_grace_reg <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Range table: one register per entry, written at its own index
    for (genvar g = 0; g < RANGE_ENTRIES; g++)
    begin : g_range
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                range_reg[g] <= '0;
            end
            else if (cfg_we && cfg.index == CFG_INDEX_W'(int'(REG_RANGE_0) + g))
            begin
                range_reg[g] <= range_entry_t'(cfg.data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register and result register handshake
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s1_kind_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;

    logic s1_adv;
    logic item_acc;

    // Advance the held item when the result slot is free or being emptied
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign item_acc   = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            s1_kind_reg <= item.kind;
            s1_byte_reg <= item.rx_byte;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Link and fault state
    // ------------------------------------------------------------------
    frame_phase_t phase_reg,       phase_next;
    logic [7:0]   frame_type_reg,  frame_type_next;
    logic [15:0]  frame_value_reg, frame_value_next;
    logic [7:0]   crc_reg,         crc_next;
    logic [7:0]   errors_reg,      errors_next;
    logic         comm_reg,        comm_next;
    logic         hb_flag_reg,     hb_flag_next;
    logic         sync_reg,        sync_next;
    logic         latched_reg,     latched_next;
    logic [31:0]  uptime_reg,      uptime_next;
    logic [31:0]  last_hb_reg,     last_hb_next;
    logic [15:0]  last_boot_reg,   last_boot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            frame_type_reg  <= '0;
            frame_value_reg <= '0;
            crc_reg         <= '0;
            errors_reg      <= '0;
            comm_reg        <= 1'b0;
            hb_flag_reg     <= 1'b0;
            sync_reg        <= 1'b0;
            latched_reg     <= 1'b0;
            uptime_reg      <= '0;
            last_hb_reg     <= '0;
            last_boot_reg   <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg       <= phase_next;
            frame_type_reg  <= frame_type_next;
            frame_value_reg <= frame_value_next;
            crc_reg         <= crc_next;
            errors_reg      <= errors_next;
            comm_reg        <= comm_next;
            hb_flag_reg     <= hb_flag_next;
            sync_reg        <= sync_next;
            latched_reg     <= latched_next;
            uptime_reg      <= uptime_next;
            last_hb_reg     <= last_hb_next;
            last_boot_reg   <= last_boot_next;
        end
    end

    // ------------------------------------------------------------------
    // Range lookup: the first valid entry with a matching type decides
    // ------------------------------------------------------------------
    logic range_ok;

    always_comb
    begin
        logic hit;
        hit      = 1'b0;
        range_ok = 1'b0;
        for (int k = 0; k < RANGE_ENTRIES; k++)
        begin
            if (!hit && range_reg[k].valid && range_reg[k].ptype == frame_type_reg)
            begin
                hit      = 1'b1;
                range_ok = (frame_value_reg >= range_reg[k].lo_val) &&
                           (frame_value_reg <= range_reg[k].hi_val);
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-item state update
    // ------------------------------------------------------------------
    always_comb
    begin
        logic        err_inc;
        logic        deliver;
        logic [31:0] uptime_inc;
        logic [31:0] hb_age;

        err_inc    = 1'b0;
        deliver    = 1'b0;
        uptime_inc = (uptime_reg != '1) ? uptime_reg + 32'd1 : uptime_reg;
        hb_age     = uptime_inc - last_hb_reg;

        phase_next       = phase_reg;
        frame_type_next  = frame_type_reg;
        frame_value_next = frame_value_reg;
        crc_next         = crc_reg;
        comm_next        = comm_reg;
        hb_flag_next     = hb_flag_reg;
        sync_next        = sync_reg;
        latched_next     = latched_reg;
        uptime_next      = uptime_reg;
        last_hb_next     = last_hb_reg;
        last_boot_next   = last_boot_reg;

        if (s1_kind_reg)
        begin
            // Millisecond tick: advance uptime, check heartbeat, latch faults
            uptime_next = uptime_inc;
            if (uptime_inc < {16'd0, sync_grace_reg})
            begin
                last_hb_next = uptime_inc;
            end
            else
            begin
                hb_flag_next = hb_age > {16'd0, hb_timeout_reg};
            end
            latched_next = latched_reg | comm_reg | hb_flag_next | sync_reg;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (s1_byte_reg == start_byte_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    frame_type_next = s1_byte_reg;
                    crc_next        = crc8_feed(8'd0, s1_byte_reg);
                    phase_next      = PH_VAL_HI;
                end
                PH_VAL_HI:
                begin
                    frame_value_next = {s1_byte_reg, 8'd0};
                    crc_next         = crc8_feed(crc_reg, s1_byte_reg);
                    phase_next       = PH_VAL_LO;
                end
                PH_VAL_LO:
                begin
                    frame_value_next = {frame_value_reg[15:8], s1_byte_reg};
                    crc_next         = crc8_feed(crc_reg, s1_byte_reg);
                    phase_next       = PH_CRC;
                end
                default:
                begin
                    // Check byte: accept, route by type or drop the frame
                    if (crc_reg == s1_byte_reg)
                    begin
                        if (frame_type_reg == 8'(HEARTBEAT_TYPE))
                        begin
                            last_hb_next = uptime_reg;
                        end
                        else if (frame_type_reg == 8'(BOOT_ID_TYPE))
                        begin
                            if (uptime_reg > {16'd0, sync_grace_reg} &&
                                last_boot_reg != 16'd0 &&
                                frame_value_reg != last_boot_reg)
                            begin
                                sync_next = 1'b1;
                            end
                            last_boot_next = frame_value_reg;
                        end
                        else if (range_ok)
                        begin
                            deliver = 1'b1;
                        end
                        else
                        begin
                            err_inc = 1'b1;
                        end
                    end
                    else
                    begin
                        err_inc = 1'b1;
                    end
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // Saturate the error count at its top value
        errors_next = (err_inc && errors_reg != 8'hFF) ? errors_reg + 8'd1 : errors_reg;
        if (!s1_kind_reg && errors_next > max_errors_reg)
        begin
            comm_next = 1'b1;
        end

        result_next.packet_valid    = deliver;
        result_next.packet_type     = deliver ? frame_type_reg  : 8'd0;
        result_next.packet_value    = deliver ? frame_value_reg : 16'd0;
        result_next.error_count     = errors_next;
        result_next.comm_fault      = comm_next;
        result_next.heartbeat_fault = hb_flag_next;
        result_next.sync_fault      = sync_next;
        result_next.latched_fault   = latched_next;
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign result.valid           = out_valid_reg;
    assign result.packet_valid    = result_reg.packet_valid;
    assign result.packet_type     = result_reg.packet_type;
    assign result.packet_value    = result_reg.packet_value;
    assign result.error_count     = result_reg.error_count;
    assign result.comm_fault      = result_reg.comm_fault;
    assign result.heartbeat_fault = result_reg.heartbeat_fault;
    assign result.sync_fault      = result_reg.sync_fault;
    assign result.latched_fault   = result_reg.latched_fault;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_errors_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> errors_reg >= $past(errors_reg))
        else $error("error count decreased");

    a_comm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        comm_reg |=> comm_reg)
        else $error("comm fault cleared");

    a_latched_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        latched_reg |=> latched_reg)
        else $error("latched fault cleared");

    a_no_reserved_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.packet_valid) |->
            (result_reg.packet_type != 8'(HEARTBEAT_TYPE) &&
             result_reg.packet_type != 8'(BOOT_ID_TYPE)))
        else $error("reserved packet type delivered");

    a_frame_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_kind_reg && phase_reg == PH_CRC) |=> phase_reg == PH_HUNT)
        else $error("deframer did not return to hunting after check byte");

endmodule
`default_nettype wire

[verif/tb_framed_link_receiver_fault_monitor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_link_receiver_fault_monitor_unit
// Drives received bytes and millisecond ticks into the link receiver, keeps a
// cycle-free model of the deframer, range table and fault flags, and compares
// every status item that comes back, field by field, in order. Directed
// frames come first, then heartbeat, boot-ID, mixed traffic, back-pressure
// and comm-fault limit runs under several register settings.
// ----------------------------------------------------------------------------
module tb_framed_link_receiver_fault_monitor_unit;
    import flrfm_pkg::*;

    // Block constants and item codes
    localparam logic [7:0] HB_TYPE     = 8'd240;
    localparam logic [7:0] BOOT_TYPE   = 8'd241;
    localparam int         RANGE_SLOTS = 4;
    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_TICK   = 1'b1;
    localparam logic [7:0] CRC8_POLY   = 8'h07;

    // Indexes past the register list; the block must ignore writes there
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 4'd8;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 4'd15;

    // Give up well past the slowest legal run
    localparam longint WATCHDOG_NS = 64'd2_000_000;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    flrfm_in_if  item_ch ();
    flrfm_out_if result_ch ();
    flrfm_cfg_if cfg_ch ();

    framed_link_receiver_fault_monitor_unit #(
        .RANGE_ENTRIES  (RANGE_SLOTS),
        .HEARTBEAT_TYPE (HB_TYPE),
        .BOOT_ID_TYPE   (BOOT_TYPE)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Link model: register copies and receiver state
    // ------------------------------------------------------------------------
    logic [7:0]   cfg_start;
    logic [7:0]   cfg_max_err;
    logic [15:0]  cfg_hb_to;
    logic [15:0]  cfg_grace;
    range_entry_t cfg_range [RANGE_SLOTS];

    frame_phase_t m_phase;
    logic [7:0]   m_type;
    logic [15:0]  m_value;
    logic [7:0]   m_crc;
    logic [7:0]   m_errors;
    logic         m_comm;
    logic         m_hb;
    logic         m_sync;
    logic         m_latched;
    logic [31:0]  m_uptime;
    logic [31:0]  m_last_hb;
    logic [15:0]  m_boot;

    // Status items still owed by the block, oldest first
    result_t link_status_q [$];

    int mismatches = 0;
    int items_sent = 0;

    // Sender pacing and receiver stall controls
    bit         paced = 1'b0;
    int         burst_left = 0;
    sink_mode_t sink_mode = SINK_OPEN;
    logic [7:0] sink_pattern = 8'hB7;
    logic [2:0] pattern_pos = 3'd0;
    int         hold_request = 0;
    int         hold_left = 0;

    // Bit-serial CRC-8, MSB first: feed each data bit against the top bit
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void reset_link_model();
        cfg_start   = 8'hAA;
        cfg_max_err = 8'd10;
        cfg_hb_to   = 16'd1000;
        cfg_grace   = 16'd3000;
        for (int k = 0; k < RANGE_SLOTS; k++)
            cfg_range[k] = '0;
        m_phase   = PH_HUNT;
        m_type    = 8'h00;
        m_value   = 16'h0000;
        m_crc     = 8'h00;
        m_errors  = 8'h00;
        m_comm    = 1'b0;
        m_hb      = 1'b0;
        m_sync    = 1'b0;
        m_latched = 1'b0;
        m_uptime  = 32'd0;
        m_last_hb = 32'd0;
        m_boot    = 16'h0000;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_START_BYTE: cfg_start   = val[7:0];
            REG_MAX_ERRORS: cfg_max_err = val[7:0];
            REG_HB_TIMEOUT: cfg_hb_to   = val[15:0];
            REG_SYNC_GRACE: cfg_grace   = val[15:0];
            default:
                if (idx >= REG_RANGE_0 && idx < REG_RANGE_0 + RANGE_SLOTS)
                    cfg_range[2'(idx - REG_RANGE_0)] = range_entry_t'(val);
        endcase
    endfunction

    function automatic void bump_errors();
        if (m_errors != 8'hFF)
            m_errors++;
    endfunction

    // Handle a complete frame with good CRC; return 1 when it is delivered
    function automatic bit accept_packet(input logic [7:0] t, input logic [15:0] v);
        bit hit;
        bit ok;
        hit = 1'b0;
        ok  = 1'b0;
        if (t == HB_TYPE)
        begin
            m_last_hb = m_uptime;
            return 1'b0;
        end
        if (t == BOOT_TYPE)
        begin
            if (m_uptime > {16'd0, cfg_grace} && m_boot != 16'h0000 && v != m_boot)
                m_sync = 1'b1;
            m_boot = v;
            return 1'b0;
        end
        // first valid entry of matching type decides, later ones are shadowed
        for (int k = 0; k < RANGE_SLOTS; k++)
        begin
            if (!hit && cfg_range[k].valid && cfg_range[k].ptype == t)
            begin
                hit = 1'b1;
                ok  = (v >= cfg_range[k].lo_val) && (v <= cfg_range[k].hi_val);
            end
        end
        if (!ok)
            bump_errors();
        return ok;
    endfunction

    // Advance the model by one item and return the status it should produce
    function automatic result_t advance_link(input logic is_tick, input logic [7:0] b);
        result_t r;
        r = '0;
        if (is_tick)
        begin
            if (m_uptime != 32'hFFFF_FFFF)
                m_uptime++;
            if (m_uptime < {16'd0, cfg_grace})
                m_last_hb = m_uptime;
            else
                m_hb = (m_uptime - m_last_hb) > {16'd0, cfg_hb_to};
            if (m_comm || m_hb || m_sync)
                m_latched = 1'b1;
        end
        else
        begin
            case (m_phase)
                PH_HUNT:
                    if (b == cfg_start)
                        m_phase = PH_TYPE;
                PH_TYPE:
                begin
                    m_type  = b;
                    m_crc   = crc8_next(8'h00, b);
                    m_phase = PH_VAL_HI;
                end
                PH_VAL_HI:
                begin
                    m_value = {b, 8'h00};
                    m_crc   = crc8_next(m_crc, b);
                    m_phase = PH_VAL_LO;
                end
                PH_VAL_LO:
                begin
                    m_value[7:0] = b;
                    m_crc        = crc8_next(m_crc, b);
                    m_phase      = PH_CRC;
                end
                default:
                begin
                    if (m_crc == b)
                    begin
                        if (accept_packet(m_type, m_value))
                        begin
                            r.packet_valid = 1'b1;
                            r.packet_type  = m_type;
                            r.packet_value = m_value;
                        end
                    end
                    else
                        bump_errors();
                    m_phase = PH_HUNT;
                end
            endcase
            if (m_errors > cfg_max_err)
                m_comm = 1'b1;
        end
        r.error_count     = m_errors;
        r.comm_fault      = m_comm;
        r.heartbeat_fault = m_hb;
        r.sync_fault      = m_sync;
        r.latched_fault   = m_latched;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s is %0h, model says %0h", name, got, want));
    endtask

    // Sample on the rising edge, before the block's own updates land
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (link_status_q.size() == 0)
                note_mismatch("status item with nothing outstanding");
            else
            begin
                want = link_status_q.pop_front();
                compare_field("packet_valid", 16'(result_ch.packet_valid),
                              16'(want.packet_valid));
                compare_field("packet_type", 16'(result_ch.packet_type),
                              16'(want.packet_type));
                compare_field("packet_value", result_ch.packet_value, want.packet_value);
                compare_field("error_count", 16'(result_ch.error_count),
                              16'(want.error_count));
                compare_field("comm_fault", 16'(result_ch.comm_fault),
                              16'(want.comm_fault));
                compare_field("heartbeat_fault", 16'(result_ch.heartbeat_fault),
                              16'(want.heartbeat_fault));
                compare_field("sync_fault", 16'(result_ch.sync_fault),
                              16'(want.sync_fault));
                compare_field("latched_fault", 16'(result_ch.latched_fault),
                              16'(want.latched_fault));
            end
        end
    end

    // Receiver: honour a hold-off request first, else stall per current mode
    always @(negedge clk)
    begin : drive_result_ready
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_OPEN:   result_ch.ready <= 1'b1;
                SINK_RANDOM: result_ch.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    result_ch.ready <= sink_pattern[pattern_pos];
                    pattern_pos = pattern_pos + 3'd1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one item from the falling edge and hold it until accepted
    task automatic send_item(input logic k, input logic [7:0] b);
        int gap;
        if (paced && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge clk);
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= k;
        item_ch.rx_byte <= b;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        link_status_q.push_back(advance_link(k, b));
        items_sent++;
        if (burst_left != 0)
            burst_left--;
    endtask

    // Send a whole frame; a nonzero flip corrupts the CRC byte
    task automatic send_frame(input logic [7:0] t, input logic [15:0] v,
                              input logic [7:0] flip);
        logic [7:0] c;
        c = crc8_next(crc8_next(crc8_next(8'h00, t), v[15:8]), v[7:0]) ^ flip;
        send_item(KIND_BYTE, cfg_start);
        send_item(KIND_BYTE, t);
        send_item(KIND_BYTE, v[15:8]);
        send_item(KIND_BYTE, v[7:0]);
        send_item(KIND_BYTE, c);
    endtask

    // Drop valid and wait until every owed status item has come back
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (link_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Fill the bits above a register's width with junk the block must mask
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                       input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        keep = ({{(CFG_DATA_W-1){1'b0}}, 1'b1} << width) - CFG_DATA_W'(1);
        junk = CFG_DATA_W'({$urandom, $urandom});
        return (junk & ~keep) | (v & keep);
    endfunction

    function automatic range_entry_t random_entry();
        range_entry_t e;
        logic [15:0]  swap;
        e.valid = ($urandom_range(0, 4) != 0);
        // draw from a small type pool so entries collide and shadow each other
        e.ptype  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h10 + 8'($urandom_range(0, 2));
        e.lo_val = 16'($urandom);
        e.hi_val = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                               : e.lo_val + 16'($urandom_range(0, 64));
        if ($urandom_range(0, 4) != 0 && e.lo_val > e.hi_val)
        begin
            swap     = e.lo_val;
            e.lo_val = e.hi_val;
            e.hi_val = swap;
        end
        return e;
    endfunction

    // One random event: mostly well-formed frames aimed at the range table,
    // plus ticks, noise, cut-short frames and corrupted CRCs
    task automatic random_link_event();
        int           pick;
        int           n;
        range_entry_t e;
        logic [7:0]   t;
        logic [15:0]  v;
        logic [7:0]   flip;
        pick = $urandom_range(0, 99);
        flip = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        if (pick < 15)
            send_item(KIND_TICK, 8'($urandom));
        else if (pick < 23)
            send_item(KIND_BYTE, 8'($urandom));
        else if (pick < 27)
        begin
            send_item(KIND_BYTE, cfg_start);
            n = $urandom_range(1, 3);
            repeat (n) send_item(KIND_BYTE, 8'($urandom));
        end
        else
        begin
            e = cfg_range[2'($urandom_range(0, RANGE_SLOTS - 1))];
            t = e.ptype;
            case ($urandom_range(0, 5))
                0: v = e.lo_val;
                1: v = e.hi_val;
                2: v = e.lo_val - 16'd1;
                3: v = e.hi_val + 16'd1;
                4: v = (e.lo_val <= e.hi_val)
                       ? e.lo_val + 16'($urandom_range(0, e.hi_val - e.lo_val))
                       : 16'($urandom);
                default: v = 16'($urandom);
            endcase
            if (pick < 40)
                t = 8'($urandom);
            else if (pick < 48)
                t = HB_TYPE;
            else if (pick < 54)
            begin
                t = BOOT_TYPE;
                v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : m_boot;
            end
            send_frame(t, v, flip);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked frames under reset defaults (start byte 0xAA)
    task automatic test_directed_frames();
        write_reg(CFG_INDEX_W'(REG_RANGE_0 + 0),
                  range_entry_t'{1'b1, 8'h10, 16'h0100, 16'h0200});
        // same type, wider range: shadowed by the entry above
        write_reg(CFG_INDEX_W'(REG_RANGE_0 + 1),
                  range_entry_t'{1'b1, 8'h10, 16'h0000, 16'hFFFF});
        // min above max: rejects every value of its type
        write_reg(CFG_INDEX_W'(REG_RANGE_0 + 2),
                  range_entry_t'{1'b1, 8'h20, 16'h0005, 16'h0003});
        write_reg(CFG_INDEX_W'(REG_RANGE_0 + 3),
                  range_entry_t'{1'b1, 8'hFF, 16'h0000, 16'hFFFF});
        paced     = 1'b0;
        sink_mode = SINK_OPEN;
        // value low byte equals the start byte: frame data, not a resync
        send_frame(8'h10, 16'h01AA, 8'h00);
        send_frame(8'h10, 16'h0300, 8'h00);
        send_frame(8'h20, 16'h0004, 8'h00);
        send_frame(8'h00, 16'h0000, 8'h00);
        send_frame(8'hFF, 16'hFFFF, 8'h00);
        send_frame(8'h10, 16'h0150, 8'h01);
        // rx_byte carries junk on ticks and must be ignored
        send_item(KIND_TICK, 8'hFF);
        send_item(KIND_TICK, 8'h00);
    endtask

    // Heartbeat refresh against timeout once past a short grace period
    task automatic test_heartbeat_timeout();
        int target;
        int pick;
        settle();
        write_reg(REG_SYNC_GRACE, with_junk(41'd8, 16));
        write_reg(REG_HB_TIMEOUT, with_junk(41'd0, 16));
        paced     = 1'b1;
        sink_mode = SINK_RANDOM;
        for (int round = 0; round < 2; round++)
        begin
            target = items_sent + ((round == 0) ? 30 : 90);
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    send_item(KIND_TICK, 8'($urandom));
                else if (pick < 9)
                    send_frame(HB_TYPE, 16'($urandom),
                               ($urandom_range(0, 7) == 0) ? 8'h5A : 8'h00);
                else
                    send_item(KIND_BYTE, 8'($urandom));
            end
            settle();
            write_reg(REG_HB_TIMEOUT, with_junk(CFG_DATA_W'($urandom_range(3, 12)), 16));
            sink_mode    = SINK_PATTERN;
            sink_pattern = 8'($urandom) | 8'h01;
        end
    endtask

    // Boot-ID changes: harmless inside the grace period, a fault after it
    task automatic test_boot_id_watch();
        int target;
        int pick;
        settle();
        write_reg(REG_SYNC_GRACE, with_junk(41'd65535, 16));
        write_reg(REG_HB_TIMEOUT, with_junk(41'd65535, 16));
        paced     = 1'b0;
        sink_mode = SINK_RANDOM;
        send_frame(BOOT_TYPE, 16'h0000, 8'h00);
        send_item(KIND_TICK, 8'($urandom));
        send_frame(BOOT_TYPE, 16'h1234, 8'h00);
        send_frame(BOOT_TYPE, 16'h5678, 8'h00);
        send_item(KIND_TICK, 8'($urandom));
        settle();
        write_reg(REG_SYNC_GRACE, with_junk(41'd0, 16));
        paced  = 1'b1;
        target = items_sent + 70;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_item(KIND_TICK, 8'($urandom));
            else if (pick < 17)
                send_frame(BOOT_TYPE,
                           (pick < 15) ? m_boot : ((pick == 15) ? 16'h0000 : 16'($urandom)),
                           8'h00);
            else
                send_frame(HB_TYPE, 16'($urandom), 8'h00);
        end
    endtask

    // Random traffic under several random register settings
    task automatic test_mixed_traffic();
        int                    target;
        logic [7:0]            sb;
        logic [CFG_INDEX_W-1:0] slot;
        for (int round = 0; round < 3; round++)
        begin
            settle();
            // start byte at both extremes, then a random one
            sb = (round == 0) ? 8'h00 : ((round == 1) ? 8'hFF : 8'($urandom));
            write_reg(REG_START_BYTE, with_junk(CFG_DATA_W'(sb), 8));
            write_reg(REG_MAX_ERRORS, with_junk(CFG_DATA_W'($urandom_range(150, 255)), 8));
            write_reg(REG_HB_TIMEOUT, with_junk(CFG_DATA_W'($urandom_range(0, 40)), 16));
            write_reg(REG_SYNC_GRACE, with_junk(CFG_DATA_W'($urandom_range(0, 30)), 16));
            for (int k = 0; k < RANGE_SLOTS; k++)
            begin
                slot = CFG_INDEX_W'(REG_RANGE_0 + k);
                write_reg(slot, random_entry());
            end
            write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      CFG_DATA_W'({$urandom, $urandom}));
            paced        = (round != 1);
            sink_mode    = sink_mode_t'(round);
            sink_pattern = 8'($urandom) | 8'h01;
            target       = items_sent + 110;
            while (items_sent < target)
                random_link_event();
        end
    endtask

    // Hold the result side off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        int target;
        settle();
        paced        = 1'b0;
        sink_mode    = SINK_OPEN;
        hold_request = 48;
        target       = items_sent + 40;
        while (items_sent < target)
            random_link_event();
        settle();
        paced        = 1'b1;
        sink_mode    = SINK_RANDOM;
        hold_request = 30;
        target       = items_sent + 20;
        while (items_sent < target)
            random_link_event();
    endtask

    // Set the error limit just above the current count, then push past it
    task automatic test_comm_fault_limit();
        logic [7:0] limit;
        settle();
        limit = (m_errors > 8'd250) ? 8'hFF : m_errors + 8'd2;
        write_reg(REG_MAX_ERRORS, with_junk(CFG_DATA_W'(limit), 8));
        paced     = 1'b0;
        sink_mode = SINK_OPEN;
        // corrupted check bytes count errors until the count crosses the limit
        repeat (4) send_frame(8'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
        settle();
        write_reg(REG_MAX_ERRORS, with_junk(41'd0, 8));
        send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_TICK, 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial
    begin : run_tests
        // drive every input to a known level before the first edge
        item_ch.valid   = 1'b0;
        item_ch.kind    = KIND_BYTE;
        item_ch.rx_byte = 8'h00;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_START_BYTE;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        reset_link_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_heartbeat_timeout();
        test_boot_id_watch();
        test_mixed_traffic();
        test_output_backpressure();
        test_comm_fault_limit();

        // drain, then wait for any stray items
        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("status: fail");
        $finish;
    end

endmodule
